@@ hw/rtl/http_chunked_body_decoder_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// implication checked every edge outside reset
`define HCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// condition that must hold on the edge after a reset edge
`define HCD_ASSERT_RST(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);
`else
`define HCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HCD_ASSERT_RST(label, clk, rst_n, cons, msg)
`endif
`endif

@@ hw/rtl/hcd_pkg.sv @@
// ---------------------------------------------------------------------------
// hcd_pkg
// Types, character codes and the byte classifier of the chunked body decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

  // width of the limit register and of the running payload total
  localparam int CFG_W = 32;
  localparam logic [CFG_W-1:0] MAX_BODY_RESET = 32'd1048576;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // result status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // trailer match value after the size line's own CRLF
  localparam logic [1:0] TM_AFTER_LINE = 2'd2;
  localparam logic [1:0] TM_FULL       = 2'd3;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_DCR,
    PH_DLF,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // one classified input byte, front end to back end
  typedef struct packed {
    logic       restart;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
    logic       is_semi;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] byte_val;
  } cls_t;

  // one result item
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] status;
  } res_t;

  function automatic cls_t classify(input logic [7:0] b, input logic rst_bit);
    cls_t c;
    logic dec, alpha;
    dec        = (b >= CH_0) && (b <= CH_9);
    alpha      = ((b >= CH_LO_A) && (b <= CH_LO_F)) || ((b >= CH_UP_A) && (b <= CH_UP_F));
    c.restart  = rst_bit;
    c.is_cr    = (b == CH_CR);
    c.is_lf    = (b == CH_LF);
    c.is_blank = (b == CH_SP) || (b == CH_TAB);
    c.is_semi  = (b == CH_SEMI);
    c.is_hex   = dec || alpha;
    // letters carry their value in the low nibble offset by nine
    c.hex_val  = dec ? b[3:0] : 4'(b[3:0] + 4'd9);
    c.byte_val = b;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hcd_queue.sv @@
// ---------------------------------------------------------------------------
// hcd_queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hcd_front.sv @@
// ---------------------------------------------------------------------------
// hcd_front
// Accepts raw bytes, classifies them and queues them for the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_front
  import hcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_restart,
  output logic            in_full,
  input  wire logic       q_pop,
  output cls_t            q_item,
  output logic            q_empty
);

  cls_t cls_in;

  // character classes computed once on the way in
  assign cls_in = classify(in_byte, in_restart);

  hcd_queue #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (2)
  ) u_in_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls_in),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hcd_back.sv @@
// ---------------------------------------------------------------------------
// hcd_back
// Chunk parser state machine; one classified byte per cycle into the result
// queue, while the input queue holds a byte and the result queue is not full.
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_back
  import hcd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire cls_t             q_item,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output res_t                  out_item,
  output logic                  out_empty
);

  localparam int W     = COUNT_BITS;
  localparam int SUM_W = ((W > CFG_W) ? W : CFG_W) + 1;

  phase_t           phase_r, phase_nxt;
  logic [W-1:0]     size_accum_r, size_accum_nxt;
  logic             digits_seen_r, digits_seen_nxt;
  logic             digits_closed_r, digits_closed_nxt;
  logic             pending_cr_r, pending_cr_nxt;
  logic [W-1:0]     bytes_left_r, bytes_left_nxt;
  logic [CFG_W-1:0] body_total_r, body_total_nxt;
  logic [1:0]       trailer_match_r, trailer_match_nxt;
  logic [CFG_W-1:0] max_body_r;

  // state as seen by this byte, after an optional restart
  phase_t           e_phase;
  logic [W-1:0]     e_size;
  logic             e_seen, e_closed, e_pc;
  logic [W-1:0]     e_left;
  logic [CFG_W-1:0] e_total;
  logic [1:0]       e_tm;

  logic             step, out_full;
  logic             closed_a;
  logic [W-1:0]     size_shift;
  logic [W-1:0]     left_dec;
  logic [SUM_W-1:0] sum_total;
  logic             over_limit;
  res_t             res;

  assign step  = !q_empty && !out_full;
  assign q_pop = step;

  assign e_phase  = q_item.restart ? PH_SIZE : phase_r;
  assign e_size   = q_item.restart ? '0 : size_accum_r;
  assign e_seen   = !q_item.restart && digits_seen_r;
  assign e_closed = !q_item.restart && digits_closed_r;
  assign e_pc     = !q_item.restart && pending_cr_r;
  assign e_left   = q_item.restart ? '0 : bytes_left_r;
  assign e_total  = q_item.restart ? '0 : body_total_r;
  assign e_tm     = q_item.restart ? '0 : trailer_match_r;

  // a CR not followed by LF closes the digit run
  assign closed_a = e_closed || (e_pc && !q_item.is_lf && e_seen);

  // hex accumulate, saturating once the top nibble is in use
  assign size_shift = (e_size[W-1:W-4] != 4'd0) ? '1 : {e_size[W-5:0], q_item.hex_val};

  assign left_dec   = W'(e_left - W'(e_left != '0));
  assign sum_total  = SUM_W'(e_total) + SUM_W'(e_size);
  assign over_limit = (sum_total > SUM_W'(max_body_r));

  // next state
  always_comb begin
    phase_nxt         = e_phase;
    size_accum_nxt    = e_size;
    digits_seen_nxt   = e_seen;
    digits_closed_nxt = e_closed;
    pending_cr_nxt    = e_pc;
    bytes_left_nxt    = e_left;
    body_total_nxt    = e_total;
    trailer_match_nxt = e_tm;
    unique case (e_phase) inside
      PH_SIZE, PH_EXT: begin
        if (e_pc && q_item.is_lf) begin
          // end of size line
          pending_cr_nxt = 1'b0;
          if (!e_seen) begin
            phase_nxt = PH_ERROR;
          end else if (e_size == '0) begin
            phase_nxt         = PH_TRAILER;
            trailer_match_nxt = TM_AFTER_LINE;
          end else if (over_limit) begin
            phase_nxt = PH_ERROR;
          end else begin
            body_total_nxt = CFG_W'(sum_total);
            bytes_left_nxt = e_size;
            phase_nxt      = PH_DATA;
          end
        end else if (e_phase == PH_EXT) begin
          pending_cr_nxt = q_item.is_cr;
        end else begin
          pending_cr_nxt    = 1'b0;
          digits_closed_nxt = closed_a;
          if (q_item.is_cr) begin
            pending_cr_nxt = 1'b1;
          end else if (q_item.is_blank || q_item.is_lf) begin
            digits_closed_nxt = closed_a || e_seen;
          end else if (q_item.is_semi) begin
            phase_nxt = e_seen ? PH_EXT : PH_ERROR;
          end else if (!q_item.is_hex || closed_a) begin
            phase_nxt = PH_ERROR;
          end else begin
            size_accum_nxt  = size_shift;
            digits_seen_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_DCR;
        end
      end
      PH_DCR: begin
        phase_nxt = q_item.is_cr ? PH_DLF : PH_ERROR;
      end
      PH_DLF: begin
        if (q_item.is_lf) begin
          phase_nxt         = PH_SIZE;
          size_accum_nxt    = '0;
          digits_seen_nxt   = 1'b0;
          digits_closed_nxt = 1'b0;
          pending_cr_nxt    = 1'b0;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_TRAILER: begin
        // track progress toward CRLFCRLF
        if (!e_tm[0]) begin
          trailer_match_nxt = q_item.is_cr ? 2'(e_tm + 2'd1) : 2'd0;
        end else if (q_item.is_lf) begin
          if (e_tm == TM_FULL) begin
            phase_nxt         = PH_DONE;
            trailer_match_nxt = 2'd0;
          end else begin
            trailer_match_nxt = 2'(e_tm + 2'd1);
          end
        end else begin
          trailer_match_nxt = q_item.is_cr ? 2'd1 : 2'd0;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // result fields
  always_comb begin
    res.data_valid = (e_phase == PH_DATA);
    res.data_byte  = (e_phase == PH_DATA) ? q_item.byte_val : 8'd0;
    if (phase_nxt == PH_ERROR) begin
      res.status = ST_ERR;
    end else if (e_phase == PH_TRAILER && phase_nxt == PH_DONE) begin
      res.status = ST_DONE;
    end else begin
      res.status = ST_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIZE;
      size_accum_r    <= '0;
      digits_seen_r   <= 1'b0;
      digits_closed_r <= 1'b0;
      pending_cr_r    <= 1'b0;
      bytes_left_r    <= '0;
      body_total_r    <= '0;
      trailer_match_r <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      size_accum_r    <= size_accum_nxt;
      digits_seen_r   <= digits_seen_nxt;
      digits_closed_r <= digits_closed_nxt;
      pending_cr_r    <= pending_cr_nxt;
      bytes_left_r    <= bytes_left_nxt;
      body_total_r    <= body_total_nxt;
      trailer_match_r <= trailer_match_nxt;
    end
  end

  // body limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_r <= cfg_wr_data;
    end
  end

  hcd_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step),
    .din   (res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

@@ hw/rtl/http_chunked_body_decoder.sv @@
// Flow: a byte transferred on the input channel is registered in the input
//   queue, parsed by the back end and its result registered in the result queue.
// Throughput: one byte per cycle while neither queue stalls the back end; the
//   two-entry queues let either side stall on its own.
// Reset: synchronous, active low; empties both queues, returns the parser to
//   the size line and loads the body limit register with 1048576.
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"

// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body byte stream into payload bytes + status.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder
  import hcd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic             in_push,
  input  wire logic [7:0]       in_byte_in,
  input  wire logic             in_restart,
  output logic                  in_full,
  // result channel
  input  wire logic             out_pop,
  output logic                  out_empty,
  output logic                  out_data_valid,
  output logic [7:0]            out_data_byte,
  output logic [1:0]            out_status
);

  cls_t q_item;
  logic q_empty, q_pop;
  res_t out_item;

  hcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_byte    (in_byte_in),
    .in_restart (in_restart),
    .in_full    (in_full),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .q_empty    (q_empty)
  );

  hcd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_item      (q_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .out_empty   (out_empty)
  );

  assign out_data_valid = out_item.data_valid;
  assign out_data_byte  = out_item.data_byte;
  assign out_status     = out_item.status;

  // checks
  `HCD_ASSERT_RST(a_reset_empty, clk, rst_n, out_empty && !in_full, "queues not empty after reset")
  `HCD_ASSERT_IMP(a_status_code, clk, rst_n, !out_empty, out_status != 2'd3, "undefined status code")
  `HCD_ASSERT_IMP(a_data_busy, clk, rst_n, !out_empty && out_data_valid, out_status == ST_BUSY, "payload byte with end status")
  `HCD_ASSERT_IMP(a_data_zero, clk, rst_n, !out_empty && !out_data_valid, out_data_byte == 8'd0, "nonzero byte without payload")

endmodule

`default_nettype wire

@@ tb/http_chunked_body_decoder_test.sv @@
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// http_chunked_body_decoder_test
// Feeds chunked HTTP bodies, clean, mangled and random, through the decoder
// and checks every result transfer against a cycle-free software decoder.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_test;
  import hcd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;

  // one raw byte as offered on the input channel
  typedef struct {
    logic [7:0] b;
    logic       r;
  } raw_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_push = 1'b0;
  logic [7:0]       in_byte_in = '0;
  logic             in_restart = 1'b0;
  logic             in_full;
  logic             out_pop = 1'b0;
  logic             out_empty;
  logic             out_data_valid;
  logic [7:0]       out_data_byte;
  logic [1:0]       out_status;

  http_chunked_body_decoder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_push       (in_push),
    .in_byte_in    (in_byte_in),
    .in_restart    (in_restart),
    .in_full       (in_full),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_data_valid(out_data_valid),
    .out_data_byte (out_data_byte),
    .out_status    (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // stimulus and scoreboard storage
  raw_byte_t  tx_bytes[$];
  logic [7:0] frame_q[$];
  res_t       decoded_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit took = 1'b0;

  int fail_count = 0;
  int cycles = 0;
  int n_in = 0;
  int n_payload = 0;
  int n_complete = 0;
  int n_error = 0;
  int n_stalled = 0;

  // decoder shadow state
  logic [31:0] limit_reg = MAX_BODY_RESET;
  phase_t      ph = PH_SIZE;
  logic [31:0] acc = '0;
  logic        seen = 1'b0;
  logic        closed = 1'b0;
  logic        cr_wait = 1'b0;
  logic [31:0] left = '0;
  logic [31:0] total = '0;
  logic [1:0]  tmatch = '0;

  function automatic void parser_clear();
    ph = PH_SIZE;
    acc = '0;
    seen = 1'b0;
    closed = 1'b0;
    cr_wait = 1'b0;
    left = '0;
    total = '0;
    tmatch = '0;
  endfunction

  // LF that ends a size line: accept the chunk, start trailers or fail
  function automatic logic [1:0] close_size_line();
    cr_wait = 1'b0;
    if (!seen) begin
      ph = PH_ERROR;
      return ST_ERR;
    end
    if (acc == '0) begin
      ph = PH_TRAILER;
      tmatch = TM_AFTER_LINE;
      return ST_BUSY;
    end
    if (total > limit_reg || acc > limit_reg - total) begin
      ph = PH_ERROR;
      return ST_ERR;
    end
    total = total + acc;
    left = acc;
    ph = PH_DATA;
    return ST_BUSY;
  endfunction

  // expected result for one accepted input byte
  function automatic res_t decode_step(input logic [7:0] c, input logic rs);
    res_t r;
    int   hv;
    bit   ended;
    r.data_valid = 1'b0;
    r.data_byte = '0;
    r.status = ST_BUSY;
    hv = -1;
    ended = 1'b0;
    if (rs) parser_clear();
    case (ph)
      PH_SIZE: begin
        if (cr_wait) begin
          cr_wait = 1'b0;
          if (c == CH_LF) begin
            r.status = close_size_line();
            ended = 1'b1;
          end else if (seen) begin
            closed = 1'b1;
          end
        end
        if (!ended) begin
          if (c == CH_CR) begin
            cr_wait = 1'b1;
          end else if (c == CH_SP || c == CH_TAB || c == CH_LF) begin
            if (seen) closed = 1'b1;
          end else if (c == CH_SEMI) begin
            if (!seen) begin
              ph = PH_ERROR;
              r.status = ST_ERR;
            end else begin
              ph = PH_EXT;
            end
          end else begin
            if (c >= CH_0 && c <= CH_9) hv = int'(c) - int'(CH_0);
            else if (c >= CH_LO_A && c <= CH_LO_F) hv = int'(c) - int'(CH_LO_A) + 10;
            else if (c >= CH_UP_A && c <= CH_UP_F) hv = int'(c) - int'(CH_UP_A) + 10;
            if (hv < 0 || closed) begin
              ph = PH_ERROR;
              r.status = ST_ERR;
            end else begin
              // accumulator sticks at all ones instead of wrapping
              if ({32'd0, acc} > (64'hFFFF_FFFF - 64'(hv)) / 64'd16) acc = '1;
              else acc = acc * 32'd16 + 32'(hv);
              seen = 1'b1;
            end
          end
        end
      end
      PH_EXT: begin
        if (cr_wait && c == CH_LF) r.status = close_size_line();
        else cr_wait = (c == CH_CR);
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte = c;
        if (left != '0) left = left - 32'd1;
        if (left == '0) ph = PH_DCR;
      end
      PH_DCR: begin
        if (c == CH_CR) begin
          ph = PH_DLF;
        end else begin
          ph = PH_ERROR;
          r.status = ST_ERR;
        end
      end
      PH_DLF: begin
        if (c == CH_LF) begin
          ph = PH_SIZE;
          acc = '0;
          seen = 1'b0;
          closed = 1'b0;
          cr_wait = 1'b0;
        end else begin
          ph = PH_ERROR;
          r.status = ST_ERR;
        end
      end
      PH_TRAILER: begin
        // even count waits for CR, odd count waits for LF
        if (!tmatch[0]) begin
          tmatch = (c == CH_CR) ? tmatch + 2'd1 : 2'd0;
        end else if (c == CH_LF) begin
          if (tmatch == TM_FULL) begin
            ph = PH_DONE;
            tmatch = '0;
            r.status = ST_DONE;
          end else begin
            tmatch = tmatch + 2'd1;
          end
        end else begin
          tmatch = (c == CH_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_DONE: ;
      default: begin
        ph = PH_ERROR;
        r.status = ST_ERR;
      end
    endcase
    return r;
  endfunction

  // ---- frame building ----
  task automatic put(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic put_crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // hex size, random case, sometimes a leading zero
  task automatic put_size(input logic [31:0] v);
    string s;
    int    i;
    s = $sformatf("%0h", v);
    if ($urandom_range(3) == 0) s = {"0", s};
    for (i = 0; i < s.len(); i++) begin
      if (s[i] >= "a" && $urandom_range(1) == 1) put(8'(s[i] - 8'd32));
      else put(s[i]);
    end
  endtask

  task automatic put_blanks();
    int n;
    int k;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: put(CH_SP);
        1: put(CH_TAB);
        2: put(CH_LF);
        default: begin
          put(CH_CR);
          put(CH_SP);
        end
      endcase
    end
  endtask

  task automatic put_ext();
    int k;
    if ($urandom_range(3) == 0) begin
      put(CH_SEMI);
      for (k = 0; k < $urandom_range(1, 4); k++) put(8'($urandom_range(8'h21, 8'h7E)));
      if ($urandom_range(3) == 0) begin
        put(CH_CR);
        put("x");
      end
    end
  endtask

  // move the staged frame to the send queue, optionally damaged first
  task automatic send_frame(input bit mangle, input bit with_restart);
    int idx;
    raw_byte_t item;
    if (mangle && frame_q.size() > 1) begin
      idx = $urandom_range(frame_q.size() - 1);
      case ($urandom_range(2))
        0: frame_q[idx] = 8'($urandom_range(255));
        1: frame_q.delete(idx);
        default: while (frame_q.size() > idx + 1) void'(frame_q.pop_back());
      endcase
    end
    while (frame_q.size() > 0) begin
      item.b = frame_q.pop_front();
      item.r = with_restart;
      with_restart = 1'b0;
      tx_bytes.insert(tx_bytes.size(), item);
    end
  endtask

  // queue roughly target bytes of mostly well-formed bodies
  task automatic fill_phase(input int target);
    int queued;
    int kind;
    int n_chunks;
    int k;
    int j;
    logic [31:0] sz;
    queued = 0;
    while (queued < target) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        for (k = 0; k < $urandom_range(1, 8); k++) put(8'($urandom_range(255)));
        queued += frame_q.size();
        send_frame(1'b0, $urandom_range(3) == 0);
      end else begin
        n_chunks = $urandom_range(0, 3);
        for (k = 0; k < n_chunks; k++) begin
          if ($urandom_range(39) == 0) sz = 32'h1_0000 + $urandom_range(32'hFFFF);
          else if ($urandom_range(9) == 0) sz = $urandom_range(13, 40);
          else sz = $urandom_range(1, 12);
          put_blanks();
          put_size(sz);
          put_blanks();
          put_ext();
          put(CH_CR);
          put(CH_LF);
          if (sz <= 40) begin
            for (j = 0; j < sz; j++) put(8'($urandom_range(255)));
            put(CH_CR);
            put(CH_LF);
          end
        end
        put_blanks();
        put_size(32'd0);
        put_blanks();
        put_ext();
        put(CH_CR);
        put(CH_LF);
        for (k = 0; k < $urandom_range(0, 2); k++) begin
          put_str("X-T: ");
          put(8'($urandom_range(8'h21, 8'h7E)));
          put(CH_CR);
          put(CH_LF);
        end
        put(CH_CR);
        put(CH_LF);
        queued += frame_q.size();
        send_frame(kind < 30, 1'b1);
      end
    end
  endtask

  // wait until everything queued has been transferred and checked
  task automatic drain();
    while (tx_bytes.size() > 0 || in_push) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // ---- input driver: a new byte once the held one has transferred ----
  always @(negedge clk) begin
    raw_byte_t cur;
    if (rst_n && (!in_push || took)) begin
      if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = tx_bytes.pop_front();
        in_push <= 1'b1;
        in_byte_in <= cur.b;
        in_restart <= cur.r;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // ---- result receiver, with one long hold-off on request ----
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---- edge sampling: predict on input transfers, check output transfers ----
  always @(posedge clk) begin
    res_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      took <= in_push && !in_full;
      if (in_push && in_full) n_stalled <= n_stalled + 1;
      if (rst_n && in_push && !in_full) begin
        decoded_q.insert(decoded_q.size(), decode_step(in_byte_in, in_restart));
        n_in <= n_in + 1;
      end
      if (rst_n && out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing expected: valid %0b byte %0h status %0d",
                 out_data_valid, out_data_byte, out_status);
          fail_count = fail_count + 1;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_data_valid !== exp_r.data_valid) begin
            $error("data_valid: expected %0h, actual %0h", exp_r.data_valid, out_data_valid);
            fail_count = fail_count + 1;
          end
          if (out_data_byte !== exp_r.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", exp_r.data_byte, out_data_byte);
            fail_count = fail_count + 1;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0h, actual %0h", exp_r.status, out_status);
            fail_count = fail_count + 1;
          end
          if (exp_r.data_valid) n_payload <= n_payload + 1;
          if (exp_r.status == ST_DONE) n_complete <= n_complete + 1;
          if (exp_r.status == ST_ERR) n_error <= n_error + 1;
        end
      end
    end
  end

  // ---- sequence of phases ----
  initial begin
    int p;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 15;
    recv_idle = 69;

    // short chunk with extreme data byte, completion, then an ignored byte
    put("1");
    put_crlf();
    put(8'hFF);
    put_crlf();
    put("0");
    put_crlf();
    put_crlf();
    put("z");
    send_frame(1'b0, 1'b1);
    // bad character, then bytes after the error
    put("g");
    put(8'h00);
    send_frame(1'b0, 1'b1);
    // semicolon before digits
    put(CH_SEMI);
    send_frame(1'b0, 1'b1);
    // CRLF before any digit
    put_crlf();
    send_frame(1'b0, 1'b1);
    // digit after blanks that follow digits
    put_str("1 2");
    send_frame(1'b0, 1'b1);
    // missing CRLF after data
    put("1");
    put_crlf();
    put_str("AZ");
    send_frame(1'b0, 1'b1);
    // saturated size runs past the limit
    put_str("FFFFFFFFF");
    put_crlf();
    send_frame(1'b0, 1'b1);
    drain();

    // random phases, one limit setting each
    for (p = 0; p < 4; p++) begin
      case (p)
        1: set_limit(32'd0);
        2: set_limit(32'hFFFF_FFFF);
        3: set_limit(32'($urandom_range(5, 40)));
        default: ;
      endcase
      if (p == 0) begin
        send_idle = 15;
        recv_idle = 69;
      end else if (p == 1) begin
        send_idle = 69;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // fill the block while the receiver holds off
      if (p == 2) want_hold = 1'b1;
      fill_phase(340);
      drain();
    end

    $display("%0d bytes in, %0d payload bytes, %0d bodies complete, %0d error results",
             n_in, n_payload, n_complete, n_error);
    $display("limits tried: reset value, zero, all ones, small; %0d cycles push held by full",
             n_stalled);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_queue.sv
hw/rtl/hcd_front.sv
hw/rtl/hcd_back.sv
hw/rtl/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_test.sv
